@@ sv/spf_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the SPH pair force pipeline.
// No dependencies; every other file in this folder uses it by scoped names.

package spf_pkg;

	// Q16.16 word and config register widths
	localparam int Q_W        = 32;
	localparam int U_W        = 31;
	localparam int CFG_IDX_W  = 3;

	// Config register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PGAIN  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_VGAIN  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MASS   = 3'd3;

	// Register reset values
	localparam logic [U_W-1:0]        H_RESET     = 31'd65536;
	localparam logic signed [Q_W-1:0] PGAIN_RESET = -32'sd65536;
	localparam logic [U_W-1:0]        VGAIN_RESET = 31'd65536;
	localparam logic [U_W-1:0]        MASS_RESET  = 31'd65536;

	localparam logic signed [Q_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [Q_W-1:0] Q_MIN = 32'sh8000_0000;

	// Square root unit: 62 bit radicand, one root bit per stage
	localparam int SQRT_X_W   = 62;
	localparam int SQRT_STEPS = SQRT_X_W / 2;
	localparam int SQRT_REM_W = SQRT_STEPS + 2;

	// Divider unit: 64 bit dividend, 31 bit divisor, 48 quotient bits per lane
	localparam int DIV_NUM_W = 64;
	localparam int DEN_W     = 31;
	localparam int DIV_Q     = 48;
	localparam int DIV_LANES = 2;

	typedef struct packed {
		logic signed [Q_W-1:0] first_pos_x;
		logic signed [Q_W-1:0] first_pos_y;
		logic signed [Q_W-1:0] second_pos_x;
		logic signed [Q_W-1:0] second_pos_y;
		logic signed [Q_W-1:0] first_vel_x;
		logic signed [Q_W-1:0] first_vel_y;
		logic signed [Q_W-1:0] second_vel_x;
		logic signed [Q_W-1:0] second_vel_y;
		logic [U_W-1:0]        first_pressure;
		logic [U_W-1:0]        second_pressure;
		logic [U_W-1:0]        first_density;
		logic [U_W-1:0]        second_density;
	} spf_pair_t;

	typedef struct packed {
		logic signed [Q_W-1:0] force_x;
		logic signed [Q_W-1:0] force_y;
		logic                  in_range;
	} spf_force_t;

	// Per-pair data that rides along the pipeline next to the arithmetic units.
	typedef struct packed {
		logic                  oor;
		logic [U_W-1:0]        adx;
		logic [U_W-1:0]        ady;
		logic                  sdx;
		logic                  sdy;
		logic [Q_W:0]          advx;
		logic [Q_W:0]          advy;
		logic                  sdvx;
		logic                  sdvy;
		logic [U_W-1:0]        half;
		logic [U_W-1:0]        rp;
		logic [U_W-1:0]        rn;
		logic [U_W-1:0]        root;
		logic [U_W-1:0]        hr;
		logic                  rz;
		logic signed [Q_W-1:0] c;
		logic signed [Q_W-1:0] sx;
		logic signed [Q_W-1:0] sy;
	} spf_side_t;

	// Apply a sign to a magnitude and saturate to the signed 32 bit range.
	function automatic logic signed [Q_W-1:0] sat_mag(input logic neg, input logic [63:0] m);
		return neg ? ((m >= 64'h8000_0000) ? Q_MIN : Q_W'(~m[Q_W-1:0] + 32'd1))
		           : ((m > 64'h7FFF_FFFF) ? Q_MAX : Q_W'(m[Q_W-1:0]));
	endfunction

	function automatic logic [Q_W-1:0] mag32(input logic signed [Q_W-1:0] v);
		return v[Q_W-1] ? Q_W'(~$unsigned(v) + 32'd1) : $unsigned(v);
	endfunction

	function automatic logic [Q_W:0] mag33(input logic signed [Q_W:0] v);
		return v[Q_W] ? (Q_W+1)'(~$unsigned(v) + 33'd1) : $unsigned(v);
	endfunction

	// Saturate a 33 bit signed sum to 32 bits.
	function automatic logic signed [Q_W-1:0] sat33(input logic signed [Q_W:0] v);
		return (v[Q_W] != v[Q_W-1]) ? (v[Q_W] ? Q_MIN : Q_MAX) : $signed(v[Q_W-1:0]);
	endfunction

endpackage

@@ sv/spf_sqrt.sv @@
`timescale 1ns / 1ps
// Pipelined integer square root, one root bit resolved per register stage.
// Depends on spf_pkg for widths and the sideband struct.

module spf_sqrt (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              adv,
	input  logic                              vin,
	input  logic [spf_pkg::SQRT_X_W-1:0]      x,
	input  spf_pkg::spf_side_t                side_in,
	output logic                              vout,
	output logic [spf_pkg::SQRT_STEPS-1:0]    root,
	output spf_pkg::spf_side_t                side_out
);

	logic                                  vld_s  [spf_pkg::SQRT_STEPS+1];
	spf_pkg::spf_side_t                    side_s [spf_pkg::SQRT_STEPS+1];
	logic [spf_pkg::SQRT_STEPS-1:0]        root_s [spf_pkg::SQRT_STEPS+1];
	logic [spf_pkg::SQRT_REM_W-2:0]        rem_s  [spf_pkg::SQRT_STEPS];
	logic [spf_pkg::SQRT_X_W-1:0]          x_s    [spf_pkg::SQRT_STEPS];

	assign vld_s[0]  = vin;
	assign side_s[0] = side_in;
	assign root_s[0] = '0;
	assign rem_s[0]  = '0;
	assign x_s[0]    = x;

	for (genvar k = 1; k <= spf_pkg::SQRT_STEPS; k++) begin : g_step
		logic [spf_pkg::SQRT_REM_W-1:0] cur;
		logic [spf_pkg::SQRT_REM_W-1:0] trial;
		logic                           ge;

		always_comb begin
			cur   = {rem_s[k-1][spf_pkg::SQRT_REM_W-3:0],
			         x_s[k-1][spf_pkg::SQRT_X_W-1 -: 2]};
			trial = {root_s[k-1], 2'b01};
			ge    = (cur >= trial);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (adv) begin
				vld_s[k] <= vld_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				side_s[k] <= side_s[k-1];
				root_s[k] <= {root_s[k-1][spf_pkg::SQRT_STEPS-2:0], ge};
			end
		end

		if (k < spf_pkg::SQRT_STEPS) begin : g_rem
			always_ff @(posedge clk) begin
				if (adv) begin
					rem_s[k] <= ge ? (spf_pkg::SQRT_REM_W-1)'(cur - trial)
					               : cur[spf_pkg::SQRT_REM_W-2:0];
					x_s[k]   <= {x_s[k-1][spf_pkg::SQRT_X_W-3:0], 2'b00};
				end
			end
		end
	end

	assign vout     = vld_s[spf_pkg::SQRT_STEPS];
	assign root     = root_s[spf_pkg::SQRT_STEPS];
	assign side_out = side_s[spf_pkg::SQRT_STEPS];

endmodule

@@ sv/spf_div.sv @@
`timescale 1ns / 1ps
// Pipelined restoring divider, two lanes sharing one divisor, one quotient bit per stage.
// Depends on spf_pkg for widths and the sideband struct.

module spf_div (
	input  logic                                                    clk,
	input  logic                                                    arst_n,
	input  logic                                                    adv,
	input  logic                                                    vin,
	input  logic [spf_pkg::DIV_LANES-1:0][spf_pkg::DIV_NUM_W-1:0]   num,
	input  logic [spf_pkg::DEN_W-1:0]                               den,
	input  spf_pkg::spf_side_t                                      side_in,
	output logic                                                    vout,
	output logic [spf_pkg::DIV_LANES-1:0][spf_pkg::DIV_Q-1:0]       q,
	output logic [spf_pkg::DIV_LANES-1:0]                           ovf,
	output spf_pkg::spf_side_t                                      side_out
);

	logic                                                 vld_s  [spf_pkg::DIV_Q+1];
	spf_pkg::spf_side_t                                   side_s [spf_pkg::DIV_Q+1];
	logic [spf_pkg::DIV_LANES-1:0]                        ovf_s  [spf_pkg::DIV_Q+1];
	// Dividend bits not yet consumed shift out the top while quotient bits shift in.
	logic [spf_pkg::DIV_LANES-1:0][spf_pkg::DIV_Q-1:0]    ql_s   [spf_pkg::DIV_Q+1];
	logic [spf_pkg::DIV_LANES-1:0][spf_pkg::DEN_W-1:0]    rem_s  [spf_pkg::DIV_Q];
	logic [spf_pkg::DEN_W-1:0]                            den_s  [spf_pkg::DIV_Q];

	logic [spf_pkg::DIV_LANES-1:0][spf_pkg::DEN_W-1:0]    rem0_w;
	logic [spf_pkg::DIV_LANES-1:0]                        ovf0_w;
	logic [spf_pkg::DIV_LANES-1:0][spf_pkg::DIV_Q-1:0]    ql0_w;

	// Entry stage: the quotient overflows 48 bits when the top dividend bits reach the divisor.
	always_comb begin
		for (int l = 0; l < spf_pkg::DIV_LANES; l++) begin
			rem0_w[l] = spf_pkg::DEN_W'(num[l][spf_pkg::DIV_NUM_W-1:spf_pkg::DIV_Q]);
			ovf0_w[l] = spf_pkg::DEN_W'(num[l][spf_pkg::DIV_NUM_W-1:spf_pkg::DIV_Q]) >= den;
			ql0_w[l]  = num[l][spf_pkg::DIV_Q-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (adv) begin
			vld_s[0] <= vin;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s[0] <= side_in;
			den_s[0]  <= den;
			rem_s[0]  <= rem0_w;
			ovf_s[0]  <= ovf0_w;
			ql_s[0]   <= ql0_w;
		end
	end

	for (genvar k = 1; k <= spf_pkg::DIV_Q; k++) begin : g_step
		logic [spf_pkg::DIV_LANES-1:0][spf_pkg::DEN_W:0] cur;
		logic [spf_pkg::DIV_LANES-1:0]                   ge;
		logic [spf_pkg::DIV_LANES-1:0][spf_pkg::DIV_Q-1:0] ql_nx;

		always_comb begin
			for (int l = 0; l < spf_pkg::DIV_LANES; l++) begin
				cur[l]   = {rem_s[k-1][l], ql_s[k-1][l][spf_pkg::DIV_Q-1]};
				ge[l]    = (cur[l] >= {1'b0, den_s[k-1]});
				ql_nx[l] = {ql_s[k-1][l][spf_pkg::DIV_Q-2:0], ge[l]};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (adv) begin
				vld_s[k] <= vld_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				side_s[k] <= side_s[k-1];
				ovf_s[k]  <= ovf_s[k-1];
				ql_s[k]   <= ql_nx;
			end
		end

		if (k < spf_pkg::DIV_Q) begin : g_rem
			logic [spf_pkg::DIV_LANES-1:0][spf_pkg::DEN_W-1:0] rem_nx;

			always_comb begin
				for (int l = 0; l < spf_pkg::DIV_LANES; l++) begin
					rem_nx[l] = ge[l] ? spf_pkg::DEN_W'(cur[l] - {1'b0, den_s[k-1]})
					                  : cur[l][spf_pkg::DEN_W-1:0];
				end
			end

			always_ff @(posedge clk) begin
				if (adv) begin
					den_s[k] <= den_s[k-1];
					rem_s[k] <= rem_nx;
				end
			end
		end
	end

	assign vout     = vld_s[spf_pkg::DIV_Q];
	assign q        = ql_s[spf_pkg::DIV_Q];
	assign ovf      = ovf_s[spf_pkg::DIV_Q];
	assign side_out = side_s[spf_pkg::DIV_Q];

endmodule

@@ sv/sph_pair_force_top.sv @@
`timescale 1ns / 1ps
// Top level of the SPH pair force pipeline: config registers, multiply stages, sqrt and dividers.
// Depends on spf_pkg, spf_sqrt and spf_div.

// The block takes one neighbor pair per clock, unless stalled, and returns the
// pressure plus viscosity force to add to the first particle and subtract from the
// second, in saturated Q16.16, with in_range cleared for pairs at or beyond the
// smoothing length. The latency is set by the bit-serial units laid out in space:
// a 31 stage square root and three 49 stage dividers (pressure term by distance,
// then the scaled sum by each density), with sixteen multiply and saturate stages
// between them. A new pair is accepted every cycle; when the output beat is held
// by frc_stall, the whole pipeline freezes and pair_stall rises in the same cycle,
// so nothing in flight is lost or repeated. Configuration writes are always taken
// (cfg_ready is tied high) and must only be issued while no pair is in flight.

module sph_pair_force_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            pair_valid,
	output logic                            pair_stall,
	input  spf_pkg::spf_pair_t              pair,
	output logic                            frc_valid,
	input  logic                            frc_stall,
	output spf_pkg::spf_force_t             frc,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [spf_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [spf_pkg::Q_W-1:0]         cfg_data
);

	// Configuration registers. The squared smoothing length is kept next to them.
	logic [spf_pkg::U_W-1:0]        h_q;
	logic signed [spf_pkg::Q_W-1:0] pgain_q;
	logic [spf_pkg::U_W-1:0]        vgain_q;
	logic [spf_pkg::U_W-1:0]        mass_q;
	logic [2*spf_pkg::U_W-1:0]      hsq_q;

	logic adv;

	// Stage registers
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic v_s8, v_s9, v_s10, v_s11, v_s12, v_s13, v_s14, v_s15, v_s16;

	logic signed [spf_pkg::Q_W:0] dx_s1, dy_s1, dvx_s1, dvy_s1;
	logic [spf_pkg::U_W-1:0]      half_s1, rp_s1, rn_s1;

	spf_pkg::spf_side_t side_s2, side_s3, side_s4, side_s5, side_s6, side_s7;
	spf_pkg::spf_side_t side_s8, side_s9, side_s10, side_s11, side_s12, side_s13;
	spf_pkg::spf_side_t side_s14, side_s15;

	logic [62:0]                  pm1_s2;
	logic [2*spf_pkg::U_W-1:0]    sqx_s3, sqy_s3;
	logic [spf_pkg::SQRT_X_W-1:0] d2_s4;
	logic [62:0]                  pm2_s6;
	logic [62:0]                  pcx_s9, pcy_s9;
	logic [63:0]                  pvx_s9, pvy_s9;
	logic signed [spf_pkg::Q_W-1:0] tcx_s10, tcy_s10, tvx_s10, tvy_s10;
	logic [62:0]                  pmx_s12, pmy_s12;
	logic [spf_pkg::DIV_LANES-1:0][spf_pkg::DIV_NUM_W-1:0] num3_s13;
	logic signed [spf_pkg::Q_W-1:0] fx_s14, fy_s14;
	logic [62:0]                  pfx_s15, pfy_s15;
	logic                         negx_s15, negy_s15;
	spf_pkg::spf_force_t          frc_s16;

	// Combinational helpers between registers
	logic [spf_pkg::Q_W:0] adx_w, ady_w, advx_w, advy_w;
	logic [62:0]           d2_w;
	logic signed [spf_pkg::Q_W:0] sumx_w, sumy_w;
	logic [spf_pkg::DIV_Q-2:0]    tx_w, ty_w;
	spf_pkg::spf_side_t           nx_s2, nx_s3, nx_s4, nx_s5, nx_s7, nx_s8, nx_s11;
	spf_pkg::spf_force_t          nx_frc;

	// Unit connections
	logic                            v_sq;
	logic [spf_pkg::SQRT_STEPS-1:0]  root_sq;
	spf_pkg::spf_side_t              side_sq;

	logic [spf_pkg::DIV_LANES-1:0][spf_pkg::DIV_NUM_W-1:0] div1_num, div2_num;
	logic [spf_pkg::DEN_W-1:0]                             div1_den;
	logic                                                  v_d1, v_d2, v_d3;
	logic [spf_pkg::DIV_LANES-1:0][spf_pkg::DIV_Q-1:0]     q_d1, q_d2, q_d3;
	logic [spf_pkg::DIV_LANES-1:0]                         ovf_d1, ovf_d2, ovf_d3;
	spf_pkg::spf_side_t                                    side_d1, side_d2, side_d3;

	// The pipeline moves as one unit whenever the output beat is free or being taken.
	assign adv        = !(frc_valid && frc_stall);
	assign pair_stall = !adv;
	assign cfg_ready  = 1'b1;
	assign frc_valid  = v_s16;
	assign frc        = frc_s16;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q     <= spf_pkg::H_RESET;
			pgain_q <= spf_pkg::PGAIN_RESET;
			vgain_q <= spf_pkg::VGAIN_RESET;
			mass_q  <= spf_pkg::MASS_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				spf_pkg::CFG_SMOOTH: h_q     <= cfg_data[spf_pkg::U_W-1:0];
				spf_pkg::CFG_PGAIN:  pgain_q <= $signed(cfg_data);
				spf_pkg::CFG_VGAIN:  vgain_q <= cfg_data[spf_pkg::U_W-1:0];
				spf_pkg::CFG_MASS:   mass_q  <= cfg_data[spf_pkg::U_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// h squared is registered from h and follows it in the next cycle; a pair passes stages 1 to 3 before its use.
	always_ff @(posedge clk) begin
		hsq_q <= (2*spf_pkg::U_W)'(h_q) * (2*spf_pkg::U_W)'(h_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
			v_s12 <= 1'b0;
			v_s13 <= 1'b0;
			v_s14 <= 1'b0;
			v_s15 <= 1'b0;
			v_s16 <= 1'b0;
		end else if (adv) begin
			v_s1  <= pair_valid;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= v_sq;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= v_d1;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
			v_s12 <= v_s11;
			v_s13 <= v_d2;
			v_s14 <= v_d3;
			v_s15 <= v_s14;
			v_s16 <= v_s15;
		end
	end

	always_comb begin
		adx_w  = spf_pkg::mag33(dx_s1);
		ady_w  = spf_pkg::mag33(dy_s1);
		advx_w = spf_pkg::mag33(dvx_s1);
		advy_w = spf_pkg::mag33(dvy_s1);
		d2_w   = 63'(sqx_s3) + 63'(sqy_s3);
		sumx_w = (spf_pkg::Q_W+1)'(tcx_s10) + (spf_pkg::Q_W+1)'(tvx_s10);
		sumy_w = (spf_pkg::Q_W+1)'(tcy_s10) + (spf_pkg::Q_W+1)'(tvy_s10);
		// The first density quotient is clamped just below 2^47; any clamped value
		// saturates after the second division anyway.
		tx_w   = (ovf_d2[0] || q_d2[0][spf_pkg::DIV_Q-1]) ? '1 : q_d2[0][spf_pkg::DIV_Q-2:0];
		ty_w   = (ovf_d2[1] || q_d2[1][spf_pkg::DIV_Q-1]) ? '1 : q_d2[1][spf_pkg::DIV_Q-2:0];

		// Stage 2 sideband: magnitudes, signs and the coarse range check.
		nx_s2      = '0;
		nx_s2.oor  = (adx_w >= {2'b00, h_q}) || (ady_w >= {2'b00, h_q});
		nx_s2.adx  = adx_w[spf_pkg::U_W-1:0];
		nx_s2.ady  = ady_w[spf_pkg::U_W-1:0];
		nx_s2.sdx  = dx_s1[spf_pkg::Q_W];
		nx_s2.sdy  = dy_s1[spf_pkg::Q_W];
		nx_s2.advx = advx_w;
		nx_s2.advy = advy_w;
		nx_s2.sdvx = dvx_s1[spf_pkg::Q_W];
		nx_s2.sdvy = dvy_s1[spf_pkg::Q_W];
		nx_s2.half = half_s1;
		nx_s2.rp   = rp_s1;
		nx_s2.rn   = rn_s1;

		nx_s3   = side_s2;
		nx_s3.c = spf_pkg::sat_mag(pgain_q[spf_pkg::Q_W-1], 64'(pm1_s2 >> 16));

		nx_s4     = side_s3;
		nx_s4.oor = side_s3.oor || (d2_w >= 63'(hsq_q));

		nx_s5      = side_sq;
		nx_s5.root = root_sq;
		nx_s5.hr   = h_q - root_sq;
		nx_s5.rz   = (root_sq == '0);

		nx_s7   = side_s6;
		nx_s7.c = spf_pkg::sat_mag(side_s6.c[spf_pkg::Q_W-1], 64'(pm2_s6 >> 16));

		nx_s8   = side_d1;
		nx_s8.c = side_d1.rz ? '0
		        : spf_pkg::sat_mag(side_d1.c[spf_pkg::Q_W-1], 64'(q_d1[0]));

		nx_s11    = side_s10;
		nx_s11.sx = spf_pkg::sat33(sumx_w);
		nx_s11.sy = spf_pkg::sat33(sumy_w);

		nx_frc.force_x  = side_s15.oor ? '0 : spf_pkg::sat_mag(negx_s15, 64'(pfx_s15 >> 16));
		nx_frc.force_y  = side_s15.oor ? '0 : spf_pkg::sat_mag(negy_s15, 64'(pfy_s15 >> 16));
		nx_frc.in_range = !side_s15.oor;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// Stage 1: differences and half pressure. A zero density counts as one step.
			dx_s1   <= $signed({pair.second_pos_x[31], pair.second_pos_x})
			         - $signed({pair.first_pos_x[31], pair.first_pos_x});
			dy_s1   <= $signed({pair.second_pos_y[31], pair.second_pos_y})
			         - $signed({pair.first_pos_y[31], pair.first_pos_y});
			dvx_s1  <= $signed({pair.second_vel_x[31], pair.second_vel_x})
			         - $signed({pair.first_vel_x[31], pair.first_vel_x});
			dvy_s1  <= $signed({pair.second_vel_y[31], pair.second_vel_y})
			         - $signed({pair.first_vel_y[31], pair.first_vel_y});
			half_s1 <= spf_pkg::U_W'((32'(pair.first_pressure) + 32'(pair.second_pressure)) >> 1);
			rp_s1   <= (pair.first_density == '0) ? 31'd1 : pair.first_density;
			rn_s1   <= (pair.second_density == '0) ? 31'd1 : pair.second_density;

			// Stage 2: magnitudes, coarse range check, half pressure times gain.
			side_s2 <= nx_s2;
			pm1_s2  <= 63'(half_s1) * 63'(spf_pkg::mag32(pgain_q));

			// Stage 3: squares of the offsets and the saturated pressure coefficient.
			side_s3 <= nx_s3;
			sqx_s3  <= (2*spf_pkg::U_W)'(side_s2.adx) * (2*spf_pkg::U_W)'(side_s2.adx);
			sqy_s3  <= (2*spf_pkg::U_W)'(side_s2.ady) * (2*spf_pkg::U_W)'(side_s2.ady);

			// Stage 4: squared distance and the exact range check.
			side_s4 <= nx_s4;
			d2_s4   <= d2_w[spf_pkg::SQRT_X_W-1:0];

			// Stage 5: distance to the kernel edge.
			side_s5 <= nx_s5;

			// Stages 6 and 7: pressure coefficient times h_r.
			side_s6 <= side_s5;
			pm2_s6  <= 63'(spf_pkg::mag32(side_s5.c)) * 63'(side_s5.hr);
			side_s7 <= nx_s7;

			// Stage 8: pressure coefficient over r, zero when the particles coincide.
			side_s8 <= nx_s8;

			// Stage 9 and 10: pressure and viscosity terms per axis.
			side_s9 <= side_s8;
			pcx_s9  <= 63'(spf_pkg::mag32(side_s8.c)) * 63'(side_s8.adx);
			pcy_s9  <= 63'(spf_pkg::mag32(side_s8.c)) * 63'(side_s8.ady);
			pvx_s9  <= 64'(vgain_q) * 64'(side_s8.advx);
			pvy_s9  <= 64'(vgain_q) * 64'(side_s8.advy);

			side_s10 <= side_s9;
			tcx_s10  <= spf_pkg::sat_mag(side_s9.c[spf_pkg::Q_W-1] ^ side_s9.sdx, 64'(pcx_s9 >> 16));
			tcy_s10  <= spf_pkg::sat_mag(side_s9.c[spf_pkg::Q_W-1] ^ side_s9.sdy, 64'(pcy_s9 >> 16));
			tvx_s10  <= spf_pkg::sat_mag(side_s9.sdvx, pvx_s9 >> 16);
			tvy_s10  <= spf_pkg::sat_mag(side_s9.sdvy, pvy_s9 >> 16);

			// Stage 11: saturated sum of both terms.
			side_s11 <= nx_s11;

			// Stage 12: magnitude of the sum times h_r, fed to the density dividers.
			side_s12 <= side_s11;
			pmx_s12  <= 63'(spf_pkg::mag32(side_s11.sx)) * 63'(side_s11.hr);
			pmy_s12  <= 63'(spf_pkg::mag32(side_s11.sy)) * 63'(side_s11.hr);

			// Stage 13: clamp the first quotient and scale it for the second division.
			side_s13 <= side_d2;
			num3_s13 <= {{1'b0, ty_w, 16'h0000}, {1'b0, tx_w, 16'h0000}};

			// Stage 14: signed, saturated scaled force.
			side_s14 <= side_d3;
			fx_s14   <= spf_pkg::sat_mag(side_d3.sx[spf_pkg::Q_W-1],
			                             ovf_d3[0] ? '1 : 64'(q_d3[0]));
			fy_s14   <= spf_pkg::sat_mag(side_d3.sy[spf_pkg::Q_W-1],
			                             ovf_d3[1] ? '1 : 64'(q_d3[1]));

			// Stage 15: times the particle mass.
			side_s15 <= side_s14;
			pfx_s15  <= 63'(spf_pkg::mag32(fx_s14)) * 63'(mass_q);
			pfy_s15  <= 63'(spf_pkg::mag32(fy_s14)) * 63'(mass_q);
			negx_s15 <= fx_s14[spf_pkg::Q_W-1];
			negy_s15 <= fy_s14[spf_pkg::Q_W-1];

			// Stage 16: output register; out-of-range pairs give zero force.
			frc_s16 <= nx_frc;
		end
	end

	spf_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.vin      (v_s4),
		.x        (d2_s4),
		.side_in  (side_s4),
		.vout     (v_sq),
		.root     (root_sq),
		.side_out (side_sq)
	);

	// Pressure coefficient divided by r, where only lane 0 carries data; the second divider takes both axes.
	always_comb begin
		div1_num[0] = {16'h0000, spf_pkg::mag32(side_s7.c), 16'h0000};
		div1_num[1] = '0;
		div1_den    = side_s7.rz ? 31'd1 : side_s7.root;
		div2_num[0] = 64'(pmx_s12);
		div2_num[1] = 64'(pmy_s12);
	end

	spf_div u_div_r (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.vin      (v_s7),
		.num      (div1_num),
		.den      (div1_den),
		.side_in  (side_s7),
		.vout     (v_d1),
		.q        (q_d1),
		.ovf      (ovf_d1),
		.side_out (side_d1)
	);

	spf_div u_div_rp (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.vin      (v_s12),
		.num      (div2_num),
		.den      (side_s12.rp),
		.side_in  (side_s12),
		.vout     (v_d2),
		.q        (q_d2),
		.ovf      (ovf_d2),
		.side_out (side_d2)
	);

	spf_div u_div_rn (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.vin      (v_s13),
		.num      (num3_s13),
		.den      (side_s13.rn),
		.side_in  (side_s13),
		.vout     (v_d3),
		.q        (q_d3),
		.ovf      (ovf_d3),
		.side_out (side_d3)
	);

endmodule
